### hdl/cbt_pkg.sv
package cbt_pkg;

    // t and 1 - t: unsigned, 16 fraction bits, one integer bit
    localparam int T_W = 17;
    localparam logic [T_W-1:0] T_ONE = 17'h10000;

    // sample count register width
    localparam int N_W = 7;

    // 65536 / N is worked out one quotient bit per cycle
    localparam int DIV_STEPS = 17;
    localparam int DIV_CNT_W = 5;

    // Bernstein weights carry 48 fraction bits and are split into 24-bit halves
    localparam int WGT_FRAC = 48;
    localparam int WGT_W    = 49;
    localparam int HALF_W   = 24;

    // shared multiplier operands
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 25;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // sequencer steps: what the multiplier is issued with in each step
    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_MT_SQ = 5'd0;  // mt * mt
    localparam logic [STEP_W-1:0] STEP_T_SQ  = 5'd1;  // t * t
    localparam logic [STEP_W-1:0] STEP_W0    = 5'd2;  // mt^2 * mt
    localparam logic [STEP_W-1:0] STEP_W1    = 5'd3;  // mt^2 * t
    localparam logic [STEP_W-1:0] STEP_W2    = 5'd4;  // t^2 * mt
    localparam logic [STEP_W-1:0] STEP_W3    = 5'd5;  // t^2 * t
    localparam logic [STEP_W-1:0] STEP_COORD = 5'd6;  // first coordinate product
    localparam logic [STEP_W-1:0] STEP_ACC   = 5'd7;  // first accumulate
    localparam logic [STEP_W-1:0] STEP_LAST  = 5'd22; // last accumulate, no issue

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic start;
        logic advance;
    } tgen_ctrl_t;

    typedef struct packed {
        logic           ready;
        logic [T_W-1:0] t;
    } tgen_stat_t;

endpackage

### hdl/cbt_mul.sv
module cbt_mul
(
    input  logic                        clk,
    input  logic [cbt_pkg::MUL_A_W-1:0] a,
    input  logic [cbt_pkg::MUL_B_W-1:0] b,
    output logic [cbt_pkg::PROD_W-1:0]  prod
);

    logic [cbt_pkg::PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= cbt_pkg::PROD_W'(a) * cbt_pkg::PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

### hdl/cbt_tgen.sv
module cbt_tgen
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  cbt_pkg::tgen_ctrl_t        ctrl,
    input  logic [cbt_pkg::N_W-1:0]    n,
    output cbt_pkg::tgen_stat_t        stat
);

    logic [cbt_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [cbt_pkg::N_W-1:0]       n_reg;
    logic [cbt_pkg::N_W-1:0]       rem_reg, rem_next;
    logic [cbt_pkg::T_W-1:0]       quot_reg, quot_next;
    logic [cbt_pkg::T_W-1:0]       t_reg, t_next;
    logic [cbt_pkg::N_W-1:0]       r_reg, r_next;

    logic                          bit_in;
    logic [cbt_pkg::N_W:0]         trial;
    logic                          ge;
    logic [cbt_pkg::N_W:0]         r_sum;
    logic                          wrap;

    // restoring division of 2^16 by N; quotient and remainder give the t step
    always_comb
    begin
        bit_in    = (cnt_reg == cbt_pkg::DIV_CNT_W'(cbt_pkg::DIV_STEPS));
        trial     = {rem_reg, bit_in};
        ge        = (trial >= {1'b0, n_reg});
        rem_next  = ge ? cbt_pkg::N_W'(trial - {1'b0, n_reg}) : trial[cbt_pkg::N_W-1:0];
        quot_next = {quot_reg[cbt_pkg::T_W-2:0], ge};
        cnt_next  = cnt_reg - cbt_pkg::DIV_CNT_W'(1);
    end

    // t_i = floor((i * 2^16 + N/2) / N) kept as quotient and running remainder
    always_comb
    begin
        r_sum  = {1'b0, r_reg} + {1'b0, rem_reg};
        wrap   = (r_sum >= {1'b0, n_reg});
        r_next = wrap ? cbt_pkg::N_W'(r_sum - {1'b0, n_reg}) : r_sum[cbt_pkg::N_W-1:0];
        t_next = t_reg + quot_reg + cbt_pkg::T_W'(wrap);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (ctrl.start)
        begin
            cnt_reg <= cbt_pkg::DIV_CNT_W'(cbt_pkg::DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            n_reg    <= n;
            rem_reg  <= '0;
            quot_reg <= '0;
            t_reg    <= '0;
            r_reg    <= n >> 1;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        else if (ctrl.advance)
        begin
            t_reg <= t_next;
            r_reg <= r_next;
        end
    end

    assign stat.ready = (cnt_reg == '0);
    assign stat.t     = t_reg;

endmodule

### hdl/cubic_bezier_tessellator_unit.sv
// Each point takes 22 products through the one multiplier, then a drain step and an
// emit state that waits until the output register is free.
// A curve opens with the 17-step division of 2^16 by N (the effective sample count)
// and the first t step; a new curve is taken only after its last point is loaded.
// Reset (rst_n, asynchronous, active low): idle, no point pending, sample_count 64.
module cubic_bezier_tessellator_unit
#(
    parameter int MAX_SAMPLES = 64,
    parameter int COORD_WIDTH = 24
)
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_wr_en,
    input  logic [cbt_pkg::N_W-1:0]       cfg_wr_data,

    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl_a_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl_a_y,
    input  logic signed [COORD_WIDTH-1:0] ctrl_b_x,
    input  logic signed [COORD_WIDTH-1:0] ctrl_b_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,

    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [COORD_WIDTH-1:0] point_x,
    output logic signed [COORD_WIDTH-1:0] point_y,
    output logic                          last_point
);

    localparam int ACC_W = COORD_WIDTH + cbt_pkg::WGT_FRAC;
    localparam logic [COORD_WIDTH-1:0] BIAS = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (cbt_pkg::WGT_FRAC - 1);

    cbt_pkg::state_t             state_reg, state_next;
    logic [cbt_pkg::STEP_W-1:0]  step_reg, step_next;
    logic [cbt_pkg::N_W-1:0]     sample_count_reg;
    logic [cbt_pkg::N_W-1:0]     n_eff;
    logic [cbt_pkg::N_W-1:0]     n_reg;
    logic [cbt_pkg::N_W-1:0]     i_reg;
    logic                        out_valid_reg;

    logic [COORD_WIDTH-1:0]      qx_reg [4];
    logic [COORD_WIDTH-1:0]      qy_reg [4];
    logic [cbt_pkg::MUL_A_W-1:0] mt2_reg;
    logic [cbt_pkg::MUL_A_W-1:0] t2_reg;
    logic [cbt_pkg::WGT_W-1:0]   w_reg [4];
    logic [ACC_W-1:0]            accx_reg;
    logic [ACC_W-1:0]            accy_reg;
    logic [COORD_WIDTH-1:0]      point_x_reg;
    logic [COORD_WIDTH-1:0]      point_y_reg;
    logic                        last_reg;

    cbt_pkg::tgen_ctrl_t         tctrl;
    cbt_pkg::tgen_stat_t         tstat;
    logic [cbt_pkg::T_W-1:0]     t;
    logic [cbt_pkg::T_W-1:0]     mt;

    logic [cbt_pkg::MUL_A_W-1:0] mul_a;
    logic [cbt_pkg::MUL_B_W-1:0] mul_b;
    logic [cbt_pkg::PROD_W-1:0]  prod;
    logic [cbt_pkg::WGT_W-1:0]   prod_x3;

    logic [3:0]                  issue_op;
    logic [3:0]                  acc_op;
    logic [cbt_pkg::WGT_W-1:0]   w_sel;
    logic [COORD_WIDTH-1:0]      q_sel;
    logic [ACC_W-1:0]            acc_add;

    logic                        accept;
    logic                        load;
    logic                        last_now;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= cbt_pkg::N_W'(64);
        end
        else if (cfg_wr_en)
        begin
            sample_count_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        priority if (sample_count_reg == '0)
        begin
            n_eff = cbt_pkg::N_W'(1);
        end
        else if (sample_count_reg > cbt_pkg::N_W'(MAX_SAMPLES))
        begin
            n_eff = cbt_pkg::N_W'(MAX_SAMPLES);
        end
        else
        begin
            n_eff = sample_count_reg;
        end
    end

    // ---- parameter generator ----
    cbt_tgen u_tgen
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (tctrl),
        .n     (n_eff),
        .stat  (tstat)
    );

    assign t  = tstat.t;
    assign mt = cbt_pkg::T_ONE - t;

    // ---- sequencer ----
    assign accept   = in_valid && in_ready;
    assign last_now = (i_reg == n_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cbt_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = cbt_pkg::ST_DIV;
                end
            end
            cbt_pkg::ST_DIV:
            begin
                if (tstat.ready)
                begin
                    state_next = cbt_pkg::ST_MUL;
                end
            end
            cbt_pkg::ST_MUL:
            begin
                if (step_reg == cbt_pkg::STEP_LAST)
                begin
                    state_next = cbt_pkg::ST_EMIT;
                end
            end
            cbt_pkg::ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = last_now ? cbt_pkg::ST_IDLE : cbt_pkg::ST_MUL;
                end
            end
            default:
            begin
                state_next = cbt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        load          = 1'b0;
        tctrl.start   = 1'b0;
        tctrl.advance = 1'b0;
        step_next     = '0;
        unique case (state_reg)
            cbt_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                tctrl.start = in_valid;
            end
            cbt_pkg::ST_DIV:
            begin
                tctrl.advance = tstat.ready;
            end
            cbt_pkg::ST_MUL:
            begin
                step_next = step_reg + cbt_pkg::STEP_W'(1);
            end
            cbt_pkg::ST_EMIT:
            begin
                load          = !out_valid_reg || out_ready;
                tctrl.advance = load && !last_now;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cbt_pkg::ST_IDLE;
            step_reg      <= '0;
            i_reg         <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (accept)
            begin
                i_reg <= cbt_pkg::N_W'(1);
                n_reg <= n_eff;
            end
            else if (load)
            begin
                i_reg <= i_reg + cbt_pkg::N_W'(1);
            end
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---- control points, offset to unsigned ----
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            qx_reg[0] <= start_x  ^ BIAS;
            qy_reg[0] <= start_y  ^ BIAS;
            qx_reg[1] <= ctrl_a_x ^ BIAS;
            qy_reg[1] <= ctrl_a_y ^ BIAS;
            qx_reg[2] <= ctrl_b_x ^ BIAS;
            qy_reg[2] <= ctrl_b_y ^ BIAS;
            qx_reg[3] <= end_x    ^ BIAS;
            qy_reg[3] <= end_y    ^ BIAS;
        end
    end

    // ---- multiplier operands ----
    // coordinate ops: bit 3 axis, bits 2:1 control point, bit 0 low weight half
    assign issue_op = 4'(step_reg - cbt_pkg::STEP_COORD);
    assign w_sel    = w_reg[issue_op[2:1]];
    assign q_sel    = issue_op[3] ? qy_reg[issue_op[2:1]] : qx_reg[issue_op[2:1]];

    always_comb
    begin
        unique case (step_reg)
            cbt_pkg::STEP_MT_SQ:
            begin
                mul_a = cbt_pkg::MUL_A_W'(mt);
                mul_b = cbt_pkg::MUL_B_W'(mt);
            end
            cbt_pkg::STEP_T_SQ:
            begin
                mul_a = cbt_pkg::MUL_A_W'(t);
                mul_b = cbt_pkg::MUL_B_W'(t);
            end
            cbt_pkg::STEP_W0:
            begin
                mul_a = mt2_reg;
                mul_b = cbt_pkg::MUL_B_W'(mt);
            end
            cbt_pkg::STEP_W1:
            begin
                mul_a = mt2_reg;
                mul_b = cbt_pkg::MUL_B_W'(t);
            end
            cbt_pkg::STEP_W2:
            begin
                mul_a = t2_reg;
                mul_b = cbt_pkg::MUL_B_W'(mt);
            end
            cbt_pkg::STEP_W3:
            begin
                mul_a = t2_reg;
                mul_b = cbt_pkg::MUL_B_W'(t);
            end
            default:
            begin
                mul_a = cbt_pkg::MUL_A_W'(q_sel);
                mul_b = issue_op[0]
                      ? cbt_pkg::MUL_B_W'(w_sel[cbt_pkg::HALF_W-1:0])
                      : w_sel[cbt_pkg::WGT_W-1:cbt_pkg::HALF_W];
            end
        endcase
    end

    cbt_mul u_mul
    (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    // ---- product write-back, one step behind the issue ----
    assign prod_x3 = cbt_pkg::WGT_W'({prod[cbt_pkg::WGT_W-1:0], 1'b0})
                   + prod[cbt_pkg::WGT_W-1:0];
    assign acc_op  = 4'(step_reg - cbt_pkg::STEP_ACC);
    assign acc_add = acc_op[0] ? ACC_W'(prod) : ACC_W'({prod, {cbt_pkg::HALF_W{1'b0}}});

    always_ff @(posedge clk)
    begin
        if (state_reg == cbt_pkg::ST_MUL)
        begin
            unique case (step_reg)
                cbt_pkg::STEP_MT_SQ:
                begin
                    // rounding half preloaded, ties go up
                    accx_reg <= ROUND_HALF;
                    accy_reg <= ROUND_HALF;
                end
                cbt_pkg::STEP_T_SQ:  mt2_reg  <= prod[cbt_pkg::MUL_A_W-1:0];
                cbt_pkg::STEP_W0:    t2_reg   <= prod[cbt_pkg::MUL_A_W-1:0];
                cbt_pkg::STEP_W1:    w_reg[0] <= prod[cbt_pkg::WGT_W-1:0];
                cbt_pkg::STEP_W2:    w_reg[1] <= prod_x3;
                cbt_pkg::STEP_W3:    w_reg[2] <= prod_x3;
                cbt_pkg::STEP_COORD: w_reg[3] <= prod[cbt_pkg::WGT_W-1:0];
                default:
                begin
                    if (acc_op[3])
                    begin
                        accy_reg <= accy_reg + acc_add;
                    end
                    else
                    begin
                        accx_reg <= accx_reg + acc_add;
                    end
                end
            endcase
        end
    end

    // ---- output register ----
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            point_x_reg <= accx_reg[cbt_pkg::WGT_FRAC +: COORD_WIDTH] ^ BIAS;
            point_y_reg <= accy_reg[cbt_pkg::WGT_FRAC +: COORD_WIDTH] ^ BIAS;
            last_reg    <= last_now;
        end
    end

    assign out_valid  = out_valid_reg;
    assign point_x    = $signed(point_x_reg);
    assign point_y    = $signed(point_y_reg);
    assign last_point = last_reg;

endmodule

### hdl/cbt_checker.sv
module cbt_checker
#(
    parameter int COORD_WIDTH = 24
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [COORD_WIDTH-1:0] point_x,
    input logic [COORD_WIDTH-1:0] point_y,
    input logic                   last_point
);

    // one curve at a time: a transaction always closes the input
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("input still open after a transaction");

    // the input never closes without a transaction
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid))
    else $error("input closed without a transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("point withdrawn before transaction");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(point_x) && $stable(point_y)
                                    && $stable(last_point))
    else $error("point changed while stalled");

endmodule

bind cubic_bezier_tessellator_unit cbt_checker #(.COORD_WIDTH(COORD_WIDTH)) u_cbt_checker
(
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .point_x    (point_x),
    .point_y    (point_y),
    .last_point (last_point)
);

### tb/cubic_bezier_tessellator_unit_tb.sv
`timescale 1ns / 100ps

module cubic_bezier_tessellator_unit_tb;

    localparam int COORD_W     = 24;
    localparam int MAX_POINTS  = 64;
    localparam int IDLE_LIMIT  = 5000;
    localparam int HOLD_CYCLES = 400;

    typedef logic signed [COORD_W-1:0] coord_t;

    localparam coord_t COORD_MAX = 24'sh7FFFFF;
    localparam coord_t COORD_MIN = 24'sh800000;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t ctrl_a_x;
        coord_t ctrl_a_y;
        coord_t ctrl_b_x;
        coord_t ctrl_b_y;
        coord_t end_x;
        coord_t end_y;
    } curve_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        logic   last;
    } point_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [cbt_pkg::N_W-1:0] cfg_wr_data;
    logic                    in_valid;
    logic                    in_ready;
    coord_t                  start_x;
    coord_t                  start_y;
    coord_t                  ctrl_a_x;
    coord_t                  ctrl_a_y;
    coord_t                  ctrl_b_x;
    coord_t                  ctrl_b_y;
    coord_t                  end_x;
    coord_t                  end_y;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    coord_t                  point_x;
    coord_t                  point_y;
    logic                    last_point;

    point_t                  pending_points[$];
    logic [cbt_pkg::N_W-1:0] seg_count_reg = 7'd64;   // shadow of sample_count
    int                      mismatch_count = 0;
    int                      send_idle_pct = 0;
    int                      recv_idle_pct = 0;
    logic                    hold_req = 1'b0;
    logic                    hold_seen = 1'b0;
    int                      hold_left = 0;

    cubic_bezier_tessellator_unit
    #(
        .MAX_SAMPLES (MAX_POINTS),
        .COORD_WIDTH (COORD_W)
    )
    dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .start_x     (start_x),
        .start_y     (start_y),
        .ctrl_a_x    (ctrl_a_x),
        .ctrl_a_y    (ctrl_a_y),
        .ctrl_b_x    (ctrl_b_x),
        .ctrl_b_y    (ctrl_b_y),
        .end_x       (end_x),
        .end_y       (end_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_x     (point_x),
        .point_y     (point_y),
        .last_point  (last_point)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // weighted sum of four coordinates, weights with 48 fraction bits,
    // rounded half up to whole coordinate units
    function automatic coord_t blend(input coord_t v[4], input longint unsigned w[4]);
        logic signed [81:0] acc;
        acc = '0;
        for (int k = 0; k < 4; k++)
        begin
            acc += v[k] * $signed({18'b0, w[k]});
        end
        acc += 82'sh8000_0000_0000;
        acc = acc >>> 48;
        return acc[COORD_W-1:0];
    endfunction

    function automatic void predict_curve_points(input curve_t c);
        coord_t            xs[4];
        coord_t            ys[4];
        longint unsigned   w[4];
        int unsigned       n;
        longint unsigned   t;
        longint unsigned   mt;
        point_t            p;
        n = seg_count_reg;
        if (n < 1)
            n = 1;
        if (n > MAX_POINTS)
            n = MAX_POINTS;
        xs = '{c.start_x, c.ctrl_a_x, c.ctrl_b_x, c.end_x};
        ys = '{c.start_y, c.ctrl_a_y, c.ctrl_b_y, c.end_y};
        for (int unsigned i = 1; i <= n; i++)
        begin
            t  = (i * cbt_pkg::T_ONE + n / 2) / n;
            mt = cbt_pkg::T_ONE - t;
            w[0] = mt * mt * mt;
            w[1] = 3 * mt * mt * t;
            w[2] = 3 * mt * t * t;
            w[3] = t * t * t;
            p.x    = blend(xs, w);
            p.y    = blend(ys, w);
            p.last = (i == n);
            pending_points = {pending_points, p};
        end
    endfunction

    function automatic coord_t pick_coord();
        case ($urandom_range(3))
            0: return coord_t'(int'($urandom_range(4095)) - 2048);
            1:
            begin
                case ($urandom_range(3))
                    0: return COORD_MAX;
                    1: return COORD_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return coord_t'($urandom);
        endcase
    endfunction

    function automatic curve_t random_curve();
        curve_t c;
        c.start_x  = pick_coord();
        c.start_y  = pick_coord();
        c.ctrl_a_x = pick_coord();
        c.ctrl_a_y = pick_coord();
        c.ctrl_b_x = pick_coord();
        c.ctrl_b_y = pick_coord();
        c.end_x    = pick_coord();
        c.end_y    = pick_coord();
        return c;
    endfunction

    function automatic curve_t flat_curve(input coord_t v);
        return '{v, v, v, v, v, v, v, v};
    endfunction

    // called at a rising edge; returns at the edge of acceptance with valid still high
    task automatic send_curve(input curve_t c);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        start_x  <= c.start_x;
        start_y  <= c.start_y;
        ctrl_a_x <= c.ctrl_a_x;
        ctrl_a_y <= c.ctrl_a_y;
        ctrl_b_x <= c.ctrl_b_x;
        ctrl_b_y <= c.ctrl_b_y;
        end_x    <= c.end_x;
        end_y    <= c.end_y;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        predict_curve_points(c);
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (pending_points.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_seg_count(input logic [cbt_pkg::N_W-1:0] value);
        wait_drain();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        seg_count_reg = value;
    endtask

    // runs with the count left by reset
    task automatic test_reset_count();
        send_curve('{COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                     COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN});
        send_curve(random_curve());
    endtask

    task automatic test_extreme_points();
        write_seg_count(7'd3);
        send_curve(flat_curve(COORD_MAX));
        send_curve(flat_curve(COORD_MIN));
        send_curve(flat_curve('0));
        send_curve('{24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555,
                     24'sh555555, 24'shAAAAAA, 24'shAAAAAA, 24'sh555555});
        send_curve('{COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN,
                     COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX});
        // single-LSB coordinates
        send_curve('{24'sd1, -24'sd1, 24'sd0, 24'sd1, -24'sd1, 24'sd0, 24'sd1, -24'sd1});
    endtask

    // zero acts as one, anything above the maximum saturates
    task automatic test_count_limits();
        logic [cbt_pkg::N_W-1:0] counts[6];
        counts = '{7'd0, 7'd1, 7'd2, 7'd127, 7'd65, 7'd64};
        foreach (counts[k])
        begin
            write_seg_count(counts[k]);
            send_curve(random_curve());
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seg_count(7'd2);
        hold_req <= ~hold_req;
        repeat (10) send_curve(random_curve());
    endtask

    task automatic test_random_curves(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int round = 0; round < 6; round++)
        begin
            if (round == 2)
            begin
                write_seg_count(cbt_pkg::N_W'($urandom_range(40, 127)));
                repeat (3) send_curve(random_curve());
            end
            else
            begin
                write_seg_count(cbt_pkg::N_W'($urandom_range(0, 12)));
                repeat (25) send_curve(random_curve());
            end
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : check_point
        point_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_points.size() == 0)
            begin
                $display("%0t: point with none pending: x=%0d y=%0d last=%0b",
                         $time, point_x, point_y, last_point);
                mismatch_count++;
            end
            else
            begin
                want = pending_points.pop_front();
                if (point_x !== want.x)
                begin
                    $display("%0t: point_x expected %0d got %0d", $time, want.x, point_x);
                    mismatch_count++;
                end
                if (point_y !== want.y)
                begin
                    $display("%0t: point_y expected %0d got %0d", $time, want.y, point_y);
                    mismatch_count++;
                end
                if (last_point !== want.last)
                begin
                    $display("%0t: last_point expected %0b got %0b",
                             $time, want.last, last_point);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without any transaction
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        in_valid    <= 1'b0;
        start_x     <= '0;
        start_y     <= '0;
        ctrl_a_x    <= '0;
        ctrl_a_y    <= '0;
        ctrl_b_x    <= '0;
        ctrl_b_y    <= '0;
        end_x       <= '0;
        end_y       <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_count();
        test_extreme_points();
        test_count_limits();
        test_backpressure();
        test_random_curves(16, 63);
        test_random_curves(63, 16);
        test_random_curves(0, 0);

        wait_drain();
        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
